@@ rtl/poe_pkg.sv @@
package poe_pkg;

  // fixed field widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned HANDLE_W = 32;
  localparam int unsigned SIZE_W   = 31;
  localparam int unsigned BATCH_W  = 11;
  localparam int unsigned ROWS_W   = 11;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELIMINATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd6;

  // result kinds
  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_CLOSE  = 1'b1;

  // register reset values
  localparam logic signed [COORD_W-1:0] Y_LIMIT_RST = 32'sd65536;
  localparam logic [SIZE_W-1:0]         PIX_RST     = 31'd65536;
  localparam logic [ROWS_W-1:0]         ROWS_RST    = 11'd1024;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DECIDE,
    ST_EMIT_A,
    ST_EMIT_K,
    ST_EMIT_B,
    ST_DONE,
    ST_WRITE
  } state_e;

endpackage

@@ rtl/poe_ram.sv @@
module poe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/poe_div.sv @@
module poe_div #(
  parameter int unsigned DW = 33,
  parameter int unsigned VW = 31
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          done_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quot_q, quot_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q, dvs_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [VW:0]   trial;
  logic          ge;

  // one restoring step per cycle
  always_comb begin
    trial  = {rem_q, quot_q[DW-1]};
    ge     = trial >= {1'b0, dvs_q};
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
      quot_d = {quot_q[DW-2:0], ge};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ rtl/pixel_overlap_eliminator.sv @@
// with elimination on, the first result follows bit-serial x and y division, the tag
//   read and the decision; with it off, it follows the decision alone
// a new symbol is taken only once the last one is through: its results and, with
//   elimination on, its tag write back; receiver stalls hold the results
// a generation wrap adds a tag clearing pass through every row of the tag ram
// reset clears control state and runs the same clearing pass, during which no request is
//   taken; configuration writes are always taken
module pixel_overlap_eliminator #(
  parameter int unsigned MAX_ROWS = 1024,
  parameter int unsigned GEN_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [poe_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [31:0]                           cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [poe_pkg::COORD_W-1:0]    sym_x_i,
  input  logic signed [poe_pkg::COORD_W-1:0]    sym_y_i,
  input  logic [poe_pkg::HANDLE_W-1:0]          sym_handle_i,
  input  logic                                  end_of_call_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  kind_o,
  output logic [poe_pkg::HANDLE_W-1:0]          out_handle_o,
  output logic [poe_pkg::BATCH_W-1:0]           batch_size_o,
  output logic                                  last_of_run_o
);

  localparam int unsigned AW = $clog2(MAX_ROWS > 1 ? MAX_ROWS : 2);
  localparam int unsigned HW = $clog2(MAX_ROWS + 1);
  localparam int unsigned GW = GEN_BITS;
  localparam int unsigned CW = poe_pkg::COORD_W;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned VW = poe_pkg::SIZE_W;

  // configuration registers
  logic                       elim_q;
  logic signed [CW-1:0]       x_org_q, y_org_q, y_lim_q;
  logic [VW-1:0]              x_w_q, y_h_q;
  logic [poe_pkg::ROWS_W-1:0] rows_q;

  // block state
  poe_pkg::state_e state_q, state_d;
  logic [GW-1:0]        gen_q, gen_d;
  logic signed [CW-1:0] colx_q, colx_d;
  logic                 unset_q, unset_d;
  logic [HW-1:0]        held_q, held_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 wr_pend_q, wr_pend_d;

  // per-symbol registers
  logic [CW-1:0]        hnd_q;
  logic                 eoc_q;
  logic signed [CW-1:0] x_q;
  logic [DW-1:0]        xabs_q;
  logic                 xneg_q, ylt_q, yge_q;
  logic signed [CW-1:0] col_q;
  logic [AW-1:0]        row_q;
  logic                 a_q, k_q, b_q, clr_req_q, wr_q;
  logic [HW-1:0]        size_a_q, size_b_q;
  logic [GW-1:0]        wval_q;
  logic signed [CW-1:0] col_d;
  logic [AW-1:0]        row_d;
  logic                 a_d, k_d, b_d, clr_req_d, wr_d;
  logic [HW-1:0]        size_a_d, size_b_d;
  logic [GW-1:0]        wval_d;

  // output register
  logic                 ovld_q, ovld_d;
  logic                 okind_q, okind_d, olast_q, olast_d;
  logic [CW-1:0]        ohnd_q, ohnd_d;
  logic [HW-1:0]        osize_q, osize_d;

  // datapath helpers
  logic                 in_acc;
  logic signed [DW-1:0] xdiff_in, ydiff_in;
  logic [VW-1:0]        w_eff, h_eff;
  logic [HW-1:0]        rows_eff;
  logic                 div_start, xdiv_done, ydiv_done, div_done;
  logic [DW-1:0]        xq, yq;
  logic [VW-1:0]        xr, yr;
  logic [DW-1:0]        prod;
  logic signed [DW-1:0] col_wide;
  logic [GW-1:0]        tag;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [GW-1:0]        mem_wdata;
  logic                 slot_free;

  // decision terms
  logic signed [CW-1:0] colx_eff;
  logic signed [DW-1:0] mdiff;
  logic [DW-1:0]        mabs;
  logic                 move, mc, kept, fc, ea, eb;
  logic [GW-1:0]        g_inc_a, g_a, g_cmp, g_inc_b, g_b;
  logic                 wrap_a, wrap_b;
  logic [HW-1:0]        held1, held2, held3;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == poe_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !ovld_q || out_ready_i;

  // effective sizes and row count
  assign w_eff = (x_w_q == '0) ? VW'(1) : x_w_q;
  assign h_eff = (y_h_q == '0) ? VW'(1) : y_h_q;
  always_comb begin
    if (rows_q == '0) begin
      rows_eff = HW'(1);
    end else if (32'(rows_q) > 32'(MAX_ROWS)) begin
      rows_eff = HW'(MAX_ROWS);
    end else begin
      rows_eff = HW'(rows_q);
    end
  end

  // dividend preparation at request accept
  assign xdiff_in  = DW'(sym_x_i) - DW'(x_org_q);
  assign ydiff_in  = DW'(sym_y_i) - DW'(y_org_q);
  assign div_start = in_acc && elim_q;
  assign div_done  = xdiv_done && ydiv_done;

  poe_div #(.DW(DW), .VW(VW)) u_xdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (xdiff_in[DW-1] ? DW'(-xdiff_in) : DW'(xdiff_in)),
    .divisor_i  (w_eff),
    .done_o     (xdiv_done),
    .quot_o     (xq),
    .rem_o      (xr)
  );

  poe_div #(.DW(DW), .VW(VW)) u_ydiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DW'(ydiff_in)),
    .divisor_i  (h_eff),
    .done_o     (ydiv_done),
    .quot_o     (yq),
    .rem_o      (yr)
  );

  // column and row from the quotients
  assign prod     = xabs_q - DW'(xr);
  assign col_wide = xneg_q ? (DW'(x_org_q) - $signed(prod)) : (DW'(x_org_q) + $signed(prod));
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (state_q == poe_pkg::ST_DIV && div_done) begin
      col_d = CW'(col_wide);
      if (ylt_q) begin
        row_d = '0;
      end else if (yge_q || yq >= DW'(rows_eff)) begin
        row_d = AW'(rows_eff - HW'(1));
      end else begin
        row_d = AW'(yq);
      end
    end
  end

  // tag memory
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = row_q;
    mem_wdata = wval_q;
    if (state_q == poe_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_addr  = clr_q;
      mem_wdata = '0;
    end else if (state_q == poe_pkg::ST_WRITE) begin
      mem_we = 1'b1;
    end
  end

  poe_ram #(.WIDTH(GW), .DEPTH(MAX_ROWS)) u_tags (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (tag)
  );

  // close, keep and close decision with generation chain
  always_comb begin
    colx_eff = unset_q ? col_q : colx_q;
    mdiff    = DW'(x_q) - DW'(colx_eff);
    mabs     = mdiff[DW-1] ? DW'(-mdiff) : DW'(mdiff);
    move     = mabs > DW'(w_eff);
    g_inc_a  = gen_q + GW'(1);
    wrap_a   = (g_inc_a == '0);
    if (wrap_a) begin
      g_inc_a = GW'(1);
    end
    if (elim_q) begin
      mc    = move && (held_q != '0);
      held1 = mc ? '0 : held_q;
      g_cmp = mc ? g_inc_a : gen_q;
      kept  = (mc && wrap_a) || (tag != g_cmp);
      fc    = kept && (held1 == HW'(MAX_ROWS));
      ea    = mc || fc;
    end else begin
      mc    = 1'b0;
      held1 = held_q;
      g_cmp = gen_q;
      kept  = 1'b1;
      fc    = held_q == HW'(MAX_ROWS);
      ea    = fc;
    end
    g_a     = ea ? g_inc_a : gen_q;
    held2   = fc ? '0 : held1;
    held3   = kept ? held2 + HW'(1) : held2;
    eb      = elim_q ? (eoc_q && held3 != '0) : (held3 == HW'(MAX_ROWS));
    g_inc_b = g_a + GW'(1);
    wrap_b  = (g_inc_b == '0);
    if (wrap_b) begin
      g_inc_b = GW'(1);
    end
    g_b     = eb ? g_inc_b : g_a;
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    gen_d     = gen_q;
    colx_d    = colx_q;
    unset_d   = unset_q;
    held_d    = held_q;
    clr_d     = clr_q;
    wr_pend_d = wr_pend_q;
    a_d       = a_q;
    k_d       = k_q;
    b_d       = b_q;
    size_a_d  = size_a_q;
    size_b_d  = size_b_q;
    clr_req_d = clr_req_q;
    wr_d      = wr_q;
    wval_d    = wval_q;
    ovld_d    = ovld_q && !out_ready_i;
    okind_d   = okind_q;
    olast_d   = olast_q;
    ohnd_d    = ohnd_q;
    osize_d   = osize_q;
    unique case (state_q)
      poe_pkg::ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == AW'(MAX_ROWS - 1)) begin
          clr_d     = '0;
          wr_pend_d = 1'b0;
          state_d   = wr_pend_q ? poe_pkg::ST_WRITE : poe_pkg::ST_IDLE;
        end
      end
      poe_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_d = elim_q ? poe_pkg::ST_DIV : poe_pkg::ST_DECIDE;
        end
      end
      poe_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = poe_pkg::ST_READ;
        end
      end
      poe_pkg::ST_READ: begin
        state_d = poe_pkg::ST_DECIDE;
      end
      poe_pkg::ST_DECIDE: begin
        a_d       = ea;
        k_d       = kept;
        b_d       = eb;
        size_a_d  = held_q;
        size_b_d  = held3;
        clr_req_d = (ea && wrap_a) || (eb && wrap_b);
        wr_d      = elim_q && kept && !(eb && wrap_b);
        wval_d    = g_a;
        gen_d     = g_b;
        held_d    = eb ? '0 : held3;
        if (elim_q) begin
          unset_d = 1'b0;
          if (unset_q || move) begin
            colx_d = col_q;
          end
        end
        if (ea) begin
          state_d = poe_pkg::ST_EMIT_A;
        end else if (kept) begin
          state_d = poe_pkg::ST_EMIT_K;
        end else if (eb) begin
          state_d = poe_pkg::ST_EMIT_B;
        end else begin
          state_d = poe_pkg::ST_DONE;
        end
      end
      poe_pkg::ST_EMIT_A: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = poe_pkg::KIND_CLOSE;
          ohnd_d  = '0;
          osize_d = size_a_q;
          olast_d = !k_q && !b_q;
          if (k_q) begin
            state_d = poe_pkg::ST_EMIT_K;
          end else if (b_q) begin
            state_d = poe_pkg::ST_EMIT_B;
          end else begin
            state_d = poe_pkg::ST_DONE;
          end
        end
      end
      poe_pkg::ST_EMIT_K: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = poe_pkg::KIND_SYMBOL;
          ohnd_d  = hnd_q;
          osize_d = '0;
          olast_d = !b_q;
          state_d = b_q ? poe_pkg::ST_EMIT_B : poe_pkg::ST_DONE;
        end
      end
      poe_pkg::ST_EMIT_B: begin
        if (slot_free) begin
          ovld_d  = 1'b1;
          okind_d = poe_pkg::KIND_CLOSE;
          ohnd_d  = '0;
          osize_d = size_b_q;
          olast_d = 1'b1;
          state_d = poe_pkg::ST_DONE;
        end
      end
      poe_pkg::ST_DONE: begin
        if (clr_req_q) begin
          wr_pend_d = wr_q;
          state_d   = poe_pkg::ST_CLEAR;
        end else if (wr_q) begin
          state_d = poe_pkg::ST_WRITE;
        end else begin
          state_d = poe_pkg::ST_IDLE;
        end
      end
      poe_pkg::ST_WRITE: begin
        state_d = poe_pkg::ST_IDLE;
      end
      default: begin
        state_d = poe_pkg::ST_IDLE;
      end
    endcase
    // any listed register write reopens the column
    if (cfg_valid_i && cfg_index_i <= poe_pkg::CFG_ROWS) begin
      unset_d = 1'b1;
    end
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= poe_pkg::ST_CLEAR;
      gen_q     <= GW'(1);
      colx_q    <= '0;
      unset_q   <= 1'b1;
      held_q    <= '0;
      clr_q     <= '0;
      wr_pend_q <= 1'b0;
      ovld_q    <= 1'b0;
      elim_q    <= 1'b1;
      x_org_q   <= '0;
      y_org_q   <= '0;
      y_lim_q   <= poe_pkg::Y_LIMIT_RST;
      x_w_q     <= poe_pkg::PIX_RST;
      y_h_q     <= poe_pkg::PIX_RST;
      rows_q    <= poe_pkg::ROWS_RST;
    end else begin
      state_q   <= state_d;
      gen_q     <= gen_d;
      colx_q    <= colx_d;
      unset_q   <= unset_d;
      held_q    <= held_d;
      clr_q     <= clr_d;
      wr_pend_q <= wr_pend_d;
      ovld_q    <= ovld_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          poe_pkg::CFG_ELIMINATE: elim_q  <= cfg_data_i[0];
          poe_pkg::CFG_X_ORIGIN:  x_org_q <= cfg_data_i;
          poe_pkg::CFG_Y_ORIGIN:  y_org_q <= cfg_data_i;
          poe_pkg::CFG_Y_LIMIT:   y_lim_q <= cfg_data_i;
          poe_pkg::CFG_X_WIDTH:   x_w_q   <= cfg_data_i[VW-1:0];
          poe_pkg::CFG_Y_HEIGHT:  y_h_q   <= cfg_data_i[VW-1:0];
          poe_pkg::CFG_ROWS:      rows_q  <= cfg_data_i[poe_pkg::ROWS_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      hnd_q  <= sym_handle_i;
      eoc_q  <= end_of_call_i;
      x_q    <= sym_x_i;
      xabs_q <= xdiff_in[DW-1] ? DW'(-xdiff_in) : DW'(xdiff_in);
      xneg_q <= xdiff_in[DW-1];
      ylt_q  <= sym_y_i < y_org_q;
      yge_q  <= sym_y_i >= y_lim_q;
    end
    col_q     <= col_d;
    row_q     <= row_d;
    a_q       <= a_d;
    k_q       <= k_d;
    b_q       <= b_d;
    size_a_q  <= size_a_d;
    size_b_q  <= size_b_d;
    clr_req_q <= clr_req_d;
    wr_q      <= wr_d;
    wval_q    <= wval_d;
    okind_q   <= okind_d;
    olast_q   <= olast_d;
    ohnd_q    <= ohnd_d;
    osize_q   <= osize_d;
  end

  assign out_valid_o   = ovld_q;
  assign kind_o        = okind_q;
  assign out_handle_o  = ohnd_q;
  assign batch_size_o  = poe_pkg::BATCH_W'(osize_q);
  assign last_of_run_o = olast_q;

endmodule
